// ----- sv/assert_macros.svh -----
// assertion macros shared by the decoder rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while reset is high
`define ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ----- sv/bc1_pkg.sv -----
// types and constants of the bc1 block texel decoder
// no dependencies
package bc1_pkg;

   localparam logic [15:0] GreenMask = 16'h07E0;
   localparam logic [15:0] BlueMask  = 16'h001F;
   localparam logic [12:0] WidthReset = 13'd4096;

   typedef struct packed {
      logic [31:0] index_word;
      logic [15:0] endpoint_a;
      logic [15:0] endpoint_b;
      logic [9:0]  block_column;
      logic [9:0]  block_row;
   } req_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        inside_res;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   typedef struct packed {
      colour_type [3:0] palette;
      logic [31:0]      index_word;
      logic [9:0]       block_column;
      logic [9:0]       block_row;
   } blk_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ----- sv/bc1_front.sv -----
// front end: input register, endpoint expansion and palette build
// depends on bc1_pkg
module bc1_front import bc1_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         q_push,
   output blk_type      q_data
);

   function automatic logic [7:0] expand5(input logic [4:0] c);
      logic [13:0] t;
      logic [13:0] s;
      t = 14'(c) * 14'd255 + 14'd16;
      s = 14'(t >> 5) + t;
      return s[12:5];
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] c);
      logic [14:0] t;
      logic [14:0] s;
      t = 15'(c) * 15'd255 + 15'd32;
      s = 15'(t >> 6) + t;
      return s[13:6];
   endfunction

   // floor(x/3) for x below 768
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd683;
      return p[18:11];
   endfunction

   function automatic colour_type expand565(input logic [15:0] col);
      colour_type c;
      logic [15:0] g;
      g = (col & GreenMask) >> 5;
      c.red   = expand5(col[15:11]);
      c.green = expand6(g[5:0]);
      c.blue  = expand5(col[4:0] & BlueMask[4:0]);
      return c;
   endfunction

   function automatic logic [7:0] blend_third(input logic [7:0] a, input logic [7:0] b);
      return div3({1'b0, a, 1'b0} + {2'b0, b});
   endfunction

   function automatic logic [7:0] blend_half(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   colour_type e0, e1;
   logic       four_colour;

   assign q_push    = valid_ff && !q_status.full;
   assign req_ready = !valid_ff || !q_status.full;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   always_comb begin
      e0          = expand565(data_ff.endpoint_a);
      e1          = expand565(data_ff.endpoint_b);
      four_colour = data_ff.endpoint_a > data_ff.endpoint_b;
      q_data.palette[0] = e0;
      q_data.palette[1] = e1;
      if (four_colour) begin
         q_data.palette[2].red   = blend_third(e0.red, e1.red);
         q_data.palette[2].green = blend_third(e0.green, e1.green);
         q_data.palette[2].blue  = blend_third(e0.blue, e1.blue);
         q_data.palette[3].red   = blend_third(e1.red, e0.red);
         q_data.palette[3].green = blend_third(e1.green, e0.green);
         q_data.palette[3].blue  = blend_third(e1.blue, e0.blue);
      end else begin
         q_data.palette[2].red   = blend_half(e0.red, e1.red);
         q_data.palette[2].green = blend_half(e0.green, e1.green);
         q_data.palette[2].blue  = blend_half(e0.blue, e1.blue);
         q_data.palette[3]       = '0;
      end
      q_data.index_word   = data_ff.index_word;
      q_data.block_column = data_ff.block_column;
      q_data.block_row    = data_ff.block_row;
   end

endmodule

// ----- sv/bc1_queue.sv -----
// two-entry block queue between front and back ends
// depends on bc1_pkg
module bc1_queue import bc1_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_push,
   input  blk_type      q_data,
   input  logic         q_pop,
   output blk_type      q_head,
   output q_status_type q_status
);

   blk_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_head          = entry_ff[rd_ptr_ff];
   assign q_status.empty  = count_ff == 2'd0;
   assign q_status.full   = count_ff == 2'd2;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ q_push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, q_push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_push) begin
         entry_ff[wr_ptr_ff] <= q_data;
      end
   end

endmodule

// ----- sv/bc1_back.sv -----
// back end: texel walk over the queue head and result register
// depends on bc1_pkg
module bc1_back import bc1_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  blk_type      q_head,
   input  q_status_type q_status,
   output logic         q_pop,
   input  logic [16:0]  width_eff,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic [3:0] texel_ff, texel_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic       load;
   logic [1:0] sel;
   logic [31:0] shifted;

   assign load      = !q_status.empty && (!valid_ff || rsp_ready);
   assign q_pop     = load && (texel_ff == 4'd15);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      shifted  = q_head.index_word >> {texel_ff, 1'b0};
      sel      = shifted[1:0];
      texel_in = texel_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         texel_in            = texel_ff + 4'd1;
         valid_in            = 1'b1;
         data_in.pixel_x     = {q_head.block_column, texel_ff[1:0]};
         data_in.pixel_y     = {q_head.block_row, texel_ff[3:2]};
         data_in.red         = q_head.palette[sel].red;
         data_in.green       = q_head.palette[sel].green;
         data_in.blue        = q_head.palette[sel].blue;
         data_in.inside_res  = {5'b0, q_head.block_column, texel_ff[1:0]} < width_eff;
         data_in.last        = texel_ff == 4'd15;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texel_ff <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         texel_ff <= texel_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

// ----- sv/bc1_block_texel_decoder.sv -----
// bc1 block texel decoder: one block in, sixteen texels out in row-major order
// first texel passes the front input register, a queue entry and the result register
// then one texel per cycle while rsp_ready is high, the sustained back-end rate
// a two-entry queue lets the front end take new blocks while texels drain
// synchronous reset clears all handshake state and sets the width to 4096
// depends on bc1_pkg, bc1_front, bc1_queue, bc1_back and assert_macros.svh
`include "assert_macros.svh"
module bc1_block_texel_decoder import bc1_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data
);

   localparam logic [16:0] MaxWidth = 17'(MAX_WIDTH);

   logic [12:0]  width_ff, width_in;
   logic [16:0]  width_eff;
   q_status_type q_status;
   logic         q_push, q_pop;
   blk_type      q_data, q_head;

   assign csr_ready = 1'b1;
   assign width_in  = (csr_valid && csr_ready) ? csr_data : width_ff;
   assign width_eff = ({4'b0, width_ff} > MaxWidth) ? MaxWidth : {4'b0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WidthReset;
      end else begin
         width_ff <= width_in;
      end
   end

   bc1_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   bc1_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_status (q_status)
   );

   bc1_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .width_eff (width_eff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ASSERT_IMPL(a_push_not_full, clock, reset, q_push, !q_status.full)
   `ASSERT_IMPL(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)
   `ASSERT_IMPL(a_last_corner, clock, reset, rsp_valid && rsp_data.last, rsp_data.pixel_x[1:0] == 2'd3 && rsp_data.pixel_y[1:0] == 2'd3)
   `ASSERT_NEXT(a_pop_ends_block, clock, reset, q_pop, rsp_valid && rsp_data.last)

endmodule
